// ===== sv/mhe_pkg.sv =====
package mhe_pkg;

    // Item kinds on the mode input.
    localparam logic [2:0] MODE_INT     = 3'd0;
    localparam logic [2:0] MODE_STR     = 3'd1;
    localparam logic [2:0] MODE_BIN     = 3'd2;
    localparam logic [2:0] MODE_EXT     = 3'd3;
    localparam logic [2:0] MODE_ARRAY   = 3'd4;
    localparam logic [2:0] MODE_MAP     = 3'd5;
    localparam logic [2:0] MODE_PAYLOAD = 3'd6;

    // MessagePack format codes.
    localparam logic [7:0] FMT_FIXSTR   = 8'ha0;
    localparam logic [7:0] FMT_FIXARRAY = 8'h90;
    localparam logic [7:0] FMT_FIXMAP   = 8'h80;
    localparam logic [7:0] FMT_UINT8    = 8'hcc;
    localparam logic [7:0] FMT_UINT16   = 8'hcd;
    localparam logic [7:0] FMT_UINT32   = 8'hce;
    localparam logic [7:0] FMT_UINT64   = 8'hcf;
    localparam logic [7:0] FMT_INT8     = 8'hd0;
    localparam logic [7:0] FMT_INT16    = 8'hd1;
    localparam logic [7:0] FMT_INT32    = 8'hd2;
    localparam logic [7:0] FMT_INT64    = 8'hd3;
    localparam logic [7:0] FMT_STR8     = 8'hd9;
    localparam logic [7:0] FMT_STR16    = 8'hda;
    localparam logic [7:0] FMT_STR32    = 8'hdb;
    localparam logic [7:0] FMT_BIN8     = 8'hc4;
    localparam logic [7:0] FMT_BIN16    = 8'hc5;
    localparam logic [7:0] FMT_BIN32    = 8'hc6;
    localparam logic [7:0] FMT_FIXEXT1  = 8'hd4;
    localparam logic [7:0] FMT_FIXEXT2  = 8'hd5;
    localparam logic [7:0] FMT_FIXEXT4  = 8'hd6;
    localparam logic [7:0] FMT_FIXEXT8  = 8'hd7;
    localparam logic [7:0] FMT_FIXEXT16 = 8'hd8;
    localparam logic [7:0] FMT_EXT8     = 8'hc7;
    localparam logic [7:0] FMT_EXT16    = 8'hc8;
    localparam logic [7:0] FMT_EXT32    = 8'hc9;
    localparam logic [7:0] FMT_ARRAY16  = 8'hdc;
    localparam logic [7:0] FMT_ARRAY32  = 8'hdd;
    localparam logic [7:0] FMT_MAP16    = 8'hde;
    localparam logic [7:0] FMT_MAP32    = 8'hdf;

    // One classified item: a head byte, an optional type byte, then the
    // low nbytes bytes of value sent most significant first.
    typedef struct packed {
        logic [7:0]  head;
        logic        has_type;
        logic [7:0]  type_byte;
        logic [63:0] value;
        logic [3:0]  nbytes;
    } desc_t;

endpackage

// ===== sv/mhe_front.sv =====
module mhe_front
    import mhe_pkg::*;
(
    input  logic [2:0]         mode,
    input  logic signed [63:0] number,
    input  logic [31:0]        length,
    input  logic [7:0]         ext_type,
    input  logic [7:0]         payload_byte,
    output logic               item_ok,
    output desc_t              desc
);

    logic [63:0] num_u;
    logic [31:0] count;

    assign num_u = $unsigned(number);
    assign count = num_u[31:0];

    always_comb
    begin
        item_ok        = 1'b1;
        desc.head      = 8'h00;
        desc.has_type  = 1'b0;
        desc.type_byte = ext_type;
        desc.value     = {32'h0, length};
        desc.nbytes    = 4'd0;
        unique case (mode)
            MODE_INT:
            begin
                desc.value = num_u;
                if (!num_u[63])
                begin
                    priority if (num_u[63:7] == '0)
                        desc.head = num_u[7:0];
                    else if (num_u[63:8] == '0)
                    begin
                        desc.head = FMT_UINT8;  desc.nbytes = 4'd1;
                    end
                    else if (num_u[63:16] == '0)
                    begin
                        desc.head = FMT_UINT16; desc.nbytes = 4'd2;
                    end
                    else if (num_u[63:32] == '0)
                    begin
                        desc.head = FMT_UINT32; desc.nbytes = 4'd4;
                    end
                    else
                    begin
                        desc.head = FMT_UINT64; desc.nbytes = 4'd8;
                    end
                end
                else
                begin
                    priority if (&num_u[63:5])
                        desc.head = num_u[7:0];
                    else if (&num_u[63:7])
                    begin
                        desc.head = FMT_INT8;  desc.nbytes = 4'd1;
                    end
                    else if (&num_u[63:15])
                    begin
                        desc.head = FMT_INT16; desc.nbytes = 4'd2;
                    end
                    else if (&num_u[63:31])
                    begin
                        desc.head = FMT_INT32; desc.nbytes = 4'd4;
                    end
                    else
                    begin
                        desc.head = FMT_INT64; desc.nbytes = 4'd8;
                    end
                end
            end
            MODE_STR:
            begin
                priority if (length[31:5] == '0)
                    desc.head = FMT_FIXSTR | {3'b000, length[4:0]};
                else if (length[31:8] == '0)
                begin
                    desc.head = FMT_STR8;  desc.nbytes = 4'd1;
                end
                else if (length[31:16] == '0)
                begin
                    desc.head = FMT_STR16; desc.nbytes = 4'd2;
                end
                else
                begin
                    desc.head = FMT_STR32; desc.nbytes = 4'd4;
                end
            end
            MODE_BIN:
            begin
                priority if (length[31:8] == '0)
                begin
                    desc.head = FMT_BIN8;  desc.nbytes = 4'd1;
                end
                else if (length[31:16] == '0)
                begin
                    desc.head = FMT_BIN16; desc.nbytes = 4'd2;
                end
                else
                begin
                    desc.head = FMT_BIN32; desc.nbytes = 4'd4;
                end
            end
            MODE_EXT:
            begin
                desc.has_type = 1'b1;
                priority if (length == 32'd1)
                    desc.head = FMT_FIXEXT1;
                else if (length == 32'd2)
                    desc.head = FMT_FIXEXT2;
                else if (length == 32'd4)
                    desc.head = FMT_FIXEXT4;
                else if (length == 32'd8)
                    desc.head = FMT_FIXEXT8;
                else if (length == 32'd16)
                    desc.head = FMT_FIXEXT16;
                else if (length[31:8] == '0)
                begin
                    desc.head = FMT_EXT8;  desc.nbytes = 4'd1;
                end
                else if (length[31:16] == '0)
                begin
                    desc.head = FMT_EXT16; desc.nbytes = 4'd2;
                end
                else
                begin
                    desc.head = FMT_EXT32; desc.nbytes = 4'd4;
                end
            end
            MODE_ARRAY, MODE_MAP:
            begin
                desc.value = {32'h0, count};
                priority if (count[31:4] == '0)
                    desc.head = ((mode == MODE_ARRAY) ? FMT_FIXARRAY : FMT_FIXMAP)
                                | {4'h0, count[3:0]};
                else if (count[31:16] == '0)
                begin
                    desc.head   = (mode == MODE_ARRAY) ? FMT_ARRAY16 : FMT_MAP16;
                    desc.nbytes = 4'd2;
                end
                else
                begin
                    desc.head   = (mode == MODE_ARRAY) ? FMT_ARRAY32 : FMT_MAP32;
                    desc.nbytes = 4'd4;
                end
            end
            MODE_PAYLOAD:
                desc.head = payload_byte;
            default:
                item_ok = 1'b0;   // The unused mode produces no bytes.
        endcase
    end

endmodule

// ===== sv/mhe_queue.sv =====
module mhe_queue
    import mhe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t wdata,
    input  logic  pop,
    output desc_t rdata,
    output logic  not_empty,
    output logic  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign rdata     = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== sv/mhe_back.sv =====
module mhe_back
    import mhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       desc_valid,
    input  desc_t      desc,
    output logic       pop,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       strobe
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic [3:0] last_idx;
    logic [3:0] pos;
    logic       is_last;
    logic [7:0] byte_sel;
    logic       strobe_reg;
    logic       strobe_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       last_reg;
    logic       last_next;

    always_comb
    begin
        last_idx = desc.nbytes + {3'b000, desc.has_type};
        is_last  = (idx_reg == last_idx);
        // Byte position inside value, counted from the least significant byte.
        pos      = last_idx - idx_reg;
        priority if (idx_reg == 4'd0)
            byte_sel = desc.head;
        else if (desc.has_type && idx_reg == 4'd1)
            byte_sel = desc.type_byte;
        else
            byte_sel = desc.value[{pos[2:0], 3'b000} +: 8];

        pop           = desc_valid && is_last;
        strobe_next   = desc_valid;
        out_byte_next = byte_sel;
        last_next     = is_last;
        idx_next      = idx_reg;
        if (desc_valid)
            idx_next = is_last ? 4'd0 : idx_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= 4'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_byte = out_byte_reg;
    assign last     = last_reg;
    assign strobe   = strobe_reg;

endmodule

// ===== sv/msgpack_header_encoder_core.sv =====
// MessagePack item serializer. The user issues one item per transaction by
// raising start while busy is low; mode picks an integer, a str, bin or ext
// header, an array or map header, or a single raw payload byte, and number,
// length, ext_type and payload_byte carry the operands. Mode 7 is accepted
// and produces nothing.
// Each item becomes one to nine bytes on out_byte, one byte per cycle, each
// marked by a one-cycle strobe; last is high on the final byte of an item.
// The receiver must take every strobed byte, there is no back-pressure.
// The first byte of an item is written into the queue and then registered
// on the outputs when the serializer is free. Throughput: one transaction per
// cycle for single-byte items; an item of N bytes holds the output until all
// of its N bytes are out, and the queue between classifier and serializer
// absorbs QUEUE_DEPTH items before busy rises. The byte rate of the single
// serializer sets the limit. Reset empties the queue and clears strobe and
// busy at once; no clearing pass is needed.
module msgpack_header_encoder_core
    import mhe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         mode,
    input  logic signed [63:0] number,
    input  logic [31:0]        length,
    input  logic [7:0]         ext_type,
    input  logic [7:0]         payload_byte,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               strobe
);

    // Classified item from the front end, before it enters the queue.
    desc_t front_desc;
    logic  front_ok;
    // Head of the queue as seen by the serializer.
    desc_t head_desc;
    logic  head_valid;
    logic  queue_full;
    logic  push;
    logic  pop;

    mhe_front u_front (
        .mode         (mode),
        .number       (number),
        .length       (length),
        .ext_type     (ext_type),
        .payload_byte (payload_byte),
        .item_ok      (front_ok),
        .desc         (front_desc)
    );

    // A transaction is taken whenever the queue has room; items that make
    // no bytes are dropped here and never occupy a slot.
    assign busy = queue_full;
    assign push = start && !queue_full && front_ok;

    mhe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (front_desc),
        .pop       (pop),
        .rdata     (head_desc),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    // The serializer walks the head item one byte per cycle and frees the
    // slot in the same cycle that its last byte goes to the output register.
    mhe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (head_valid),
        .desc       (head_desc),
        .pop        (pop),
        .out_byte   (out_byte),
        .last       (last),
        .strobe     (strobe)
    );

endmodule

// ===== sv/mhe_checker.sv =====
module mhe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       busy,
    input logic [7:0] out_byte,
    input logic       last,
    input logic       strobe
);

    // Bytes already sent for the item now on the output.
    logic [3:0] run_reg;
    logic [3:0] run_next;

    always_comb
    begin
        run_next = run_reg;
        if (strobe)
            run_next = last ? 4'd0 : run_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 4'd0;
        else
            run_reg <= run_next;
    end

    // In the cycle after reset is seen low, the output strobe and the busy flag are clear.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !strobe && !busy)
        else $error("strobe or busy active during reset");

    // A full queue means the serializer is working and must emit a byte.
    a_busy_drains: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> strobe)
        else $error("queue full but no byte emitted");

    // The bytes of one item are sent without gaps.
    a_item_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside a multi-byte item");

    // No item is longer than nine bytes.
    a_item_length: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> run_reg <= 4'd8)
        else $error("item longer than nine bytes");

    // A strobed byte always carries known data.
    a_byte_known: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !$isunknown({out_byte, last}))
        else $error("strobed byte has unknown bits");

endmodule

bind msgpack_header_encoder_core mhe_checker u_mhe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .busy     (busy),
    .out_byte (out_byte),
    .last     (last),
    .strobe   (strobe)
);
